@@ sv/utf8_codepoint_width_decoder_top_defines.svh @@
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_CODEPOINT_WIDTH_DECODER_TOP_DEFINES_SVH
`define UTF8_CODEPOINT_WIDTH_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UTF8CW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UTF8CW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/utf8cw_pkg.sv @@
package utf8cw_pkg;

   // Field widths.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned CELL_W  = 2;

   // Default depth of the queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Byte class masks and patterns.
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

   localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h0FFFD;
   localparam logic [CELL_W-1:0] CELL_NARROW    = 2'd1;
   localparam logic [CELL_W-1:0] CELL_WIDE      = 2'd2;

   // Code points below this bound are always narrow.
   localparam logic [CP_W-1:0] NARROW_BOUND = 21'h00300;

   // DEC special graphics remap window.
   localparam logic [CP_W-1:0] DEC_FIRST = 21'h0005F;
   localparam logic [CP_W-1:0] DEC_LAST  = 21'h0007E;
   localparam logic [CP_W-1:0] ASCII_END = 21'h00080;

   localparam logic [15:0] DEC_GRAPHICS [32] = '{
      16'h00A0, 16'h2666, 16'h2592, 16'h2409, 16'h240C, 16'h240D, 16'h240A, 16'h00B0,
      16'h00B1, 16'h2424, 16'h240B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C,
      16'h23BA, 16'h23BB, 16'h2500, 16'h23BC, 16'h23BD, 16'h251C, 16'h2524, 16'h2534,
      16'h252C, 16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7
   };

   // Ranges of double-width code points, inclusive bounds.
   localparam int unsigned WIDE_COUNT = 16;
   localparam logic [CP_W-1:0] WIDE_LO [WIDE_COUNT] = '{
      21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03400, 21'h04E00, 21'h0A960, 21'h0AC00,
      21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF01, 21'h0FFE0, 21'h1F000, 21'h20000, 21'h30000
   };
   localparam logic [CP_W-1:0] WIDE_HI [WIDE_COUNT] = '{
      21'h0115F, 21'h0232A, 21'h0303E, 21'h033BF, 21'h04DBF, 21'h0A4CF, 21'h0A97F, 21'h0D7AF,
      21'h0FAFF, 21'h0FE1F, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F9FF, 21'h2FFFD, 21'h3FFFD
   };

   // Input transaction.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              line_drawing;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic [CELL_W-1:0] cell_width;
      logic              decode_error;
   } rsp_type;

   // Completed code point waiting for remap and width lookup.
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            line_drawing;
      logic            decode_error;
   } queue_entry_type;

   // Remaps ASCII 0x5F..0x7E through the DEC special graphics table.
   function automatic logic [CP_W-1:0] remap_dec(input logic [CP_W-1:0] cp);
      logic [4:0] idx;
      idx = 5'(cp[6:0] - DEC_FIRST[6:0]);
      if (cp >= DEC_FIRST && cp <= DEC_LAST) begin
         return {5'd0, DEC_GRAPHICS[idx]};
      end
      return cp;
   endfunction

   // Display cells of a code point: 2 inside a wide range, else 1.
   function automatic logic [CELL_W-1:0] width_of(input logic [CP_W-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < WIDE_COUNT; i++) begin
         if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
            hit = 1'b1;
         end
      end
      if (cp < NARROW_BOUND || !hit) begin
         return CELL_NARROW;
      end
      return CELL_WIDE;
   endfunction

endpackage

@@ sv/utf8cw_front.sv @@
module utf8cw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  utf8cw_pkg::req_type          req_data,
   output logic                         push,
   output utf8cw_pkg::queue_entry_type  entry
);
   import utf8cw_pkg::*;

   logic [1:0]        pending_ff, pending_in;
   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [BYTE_W-1:0] b;
   logic [CP_W-1:0]   shifted;

   assign b       = req_data.data_byte;
   assign shifted = {partial_ff[CP_W-7:0], b[5:0]};

   // Sequence state: continuation bytes still expected and bits gathered so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

   // Classify the byte and decide whether it completes a code point.
   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      push       = 1'b0;
      entry      = '{code_point: CP_W'(b), line_drawing: req_data.line_drawing,
                     decode_error: 1'b0};
      if (accept) begin
         if (pending_ff == 2'd0) begin
            if (!b[7]) begin
               push = 1'b1;
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
               partial_in = CP_W'(b[4:0]);
               pending_in = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
               partial_in = CP_W'(b[3:0]);
               pending_in = 2'd2;
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
               partial_in = CP_W'(b[2:0]);
               pending_in = 2'd3;
            end else begin
               push               = 1'b1;
               entry.code_point   = REPLACEMENT_CP;
               entry.decode_error = 1'b1;
            end
         end else if ((b & CONT_MASK) != CONT_PAT) begin
            // A non-continuation byte closes the sequence and is dropped.
            pending_in         = 2'd0;
            push               = 1'b1;
            entry.code_point   = REPLACEMENT_CP;
            entry.decode_error = 1'b1;
         end else begin
            partial_in = shifted;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               push             = 1'b1;
               entry.code_point = shifted;
            end
         end
      end
   end

endmodule

@@ sv/utf8cw_queue.sv @@
module utf8cw_queue #(
   parameter int unsigned DEPTH = utf8cw_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  utf8cw_pkg::queue_entry_type  push_data,
   output logic                         full,
   input  logic                         pop,
   output logic                         valid,
   output utf8cw_pkg::queue_entry_type  pop_data
);
   import utf8cw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slots_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/utf8cw_back.sv @@
module utf8cw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         entry_valid,
   input  utf8cw_pkg::queue_entry_type  entry,
   output logic                         entry_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output utf8cw_pkg::rsp_type          rsp_data
);
   import utf8cw_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff, out_data_in;
   logic [CP_W-1:0] cp_mapped;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign entry_pop = entry_valid && (!out_valid_ff || rsp_pop);

   // Remap ASCII under line drawing, then look up the cell width.
   always_comb begin
      cp_mapped = entry.code_point;
      if (entry.line_drawing && entry.code_point < ASCII_END) begin
         cp_mapped = remap_dec(entry.code_point);
      end
      if (entry.decode_error) begin
         out_data_in = '{code_point: REPLACEMENT_CP, cell_width: CELL_NARROW,
                         decode_error: 1'b1};
      end else begin
         out_data_in = '{code_point: cp_mapped, cell_width: width_of(cp_mapped),
                         decode_error: 1'b0};
      end
   end

   // Output register: refills in the cycle its transaction is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (entry_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

@@ sv/utf8_codepoint_width_decoder_top.sv @@
// UTF-8 decoder with display cell width.
// Input channel: one byte per transaction on req_data, taken when req_push is
// high and req_full is low. req_data.line_drawing selects the DEC special
// graphics remap for completed ASCII code points.
// Result channel: the oldest result sits on rsp_data while rsp_empty is low and
// is taken when rsp_pop is high. A lead byte or a middle continuation byte
// gives no result; an ASCII byte, a final continuation byte or a malformed
// byte gives exactly one.
// Path: a completing byte's result is written into the decode queue when the
// byte is taken, then loaded into the output register and shown on rsp_data.
// Throughput: one byte per cycle while req_full is low; the front decoder
// updates its sequence state with each byte, and the back stage does the
// remap and width lookup combinationally ahead of the output register.
// When the receiver stalls, the output register holds and the queue of
// QUEUE_DEPTH entries fills; req_full rises once it is full.
// Reset (synchronous) drops any open sequence and all waiting results.
module utf8_codepoint_width_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = utf8cw_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  utf8cw_pkg::req_type  req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output utf8cw_pkg::rsp_type  rsp_data
);
   import utf8cw_pkg::*;

   logic            accept;
   logic            q_push, q_valid, q_pop;
   queue_entry_type q_in, q_out;

   assign accept = req_push && !req_full;

   // Front: sequence tracking and byte classification.
   utf8cw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (q_push),
      .entry    (q_in)
   );

   // Queue between front and back parts.
   utf8cw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   // Back: remap, width lookup and output register.
   utf8cw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (q_valid),
      .entry       (q_out),
      .entry_pop   (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

@@ sv/utf8cw_checker.sv @@
`include "utf8_codepoint_width_decoder_top_defines.svh"

module utf8cw_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input utf8cw_pkg::req_type  req_data,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input utf8cw_pkg::rsp_type  rsp_data
);
   import utf8cw_pkg::*;

   logic rsp_valid;

   assign rsp_valid = !rsp_empty;

   // An error transaction always carries the replacement character, one cell wide.
   `UTF8CW_ASSERT_NOW(err_is_replacement, rsp_valid && rsp_data.decode_error,
      (rsp_data.code_point == REPLACEMENT_CP) && (rsp_data.cell_width == CELL_NARROW),
      "error result is not a narrow replacement character")

   // Every result occupies one or two cells.
   `UTF8CW_ASSERT_NOW(width_legal, rsp_valid,
      (rsp_data.cell_width == CELL_NARROW) || (rsp_data.cell_width == CELL_WIDE),
      "cell width is neither one nor two")

   // Leaving reset, nothing waits and input is open.
   `UTF8CW_ASSERT_NEXT(reset_clears, $fell(reset), rsp_empty && !req_full,
      "block not empty and open after reset")

   // A result that is not taken holds.
   `UTF8CW_ASSERT_NEXT(stall_holds, rsp_valid && !rsp_pop,
      rsp_valid && $stable(rsp_data), "stalled result changed")

   // A transaction offered while the block is full stays offered and unchanged.
   `UTF8CW_ASSERT_NEXT(offer_holds, req_push && req_full,
      req_push && $stable(req_data), "offered input changed while full")

endmodule

bind utf8_codepoint_width_decoder_top utf8cw_checker u_checker (.*);

@@ dv/tb_utf8_codepoint_width_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_utf8_codepoint_width_decoder_top;
   import utf8cw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 1800;
   localparam int DRAIN_CYCLES = 40;

   // DEC special graphics glyphs for ASCII 0x5F..0x7E.
   localparam logic [15:0] SPECIAL_GLYPHS [32] = '{
      16'h00A0, 16'h2666, 16'h2592, 16'h2409, 16'h240C, 16'h240D, 16'h240A, 16'h00B0,
      16'h00B1, 16'h2424, 16'h240B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C,
      16'h23BA, 16'h23BB, 16'h2500, 16'h23BC, 16'h23BD, 16'h251C, 16'h2524, 16'h2534,
      16'h252C, 16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7
   };

   // Double-width code point ranges, inclusive.
   localparam logic [CP_W-1:0] WIDE_START [16] = '{
      21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03400, 21'h04E00, 21'h0A960,
      21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF01, 21'h0FFE0, 21'h1F000,
      21'h20000, 21'h30000
   };
   localparam logic [CP_W-1:0] WIDE_STOP [16] = '{
      21'h0115F, 21'h0232A, 21'h0303E, 21'h033BF, 21'h04DBF, 21'h0A4CF, 21'h0A97F,
      21'h0D7AF, 21'h0FAFF, 21'h0FE1F, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F9FF,
      21'h2FFFD, 21'h3FFFD
   };

   localparam rsp_type BAD_BYTE_RESULT = '{REPLACEMENT_CP, CELL_NARROW, 1'b1};

   // One row of the directed byte script; want is only used when preset is set.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              line_drawing;
      logic              preset;
      rsp_type           want;
   } script_row_type;

   localparam int SCRIPT_LEN = 26;
   localparam script_row_type BYTE_SCRIPT [SCRIPT_LEN] = '{
      // Plain ASCII extremes and the edges of the line drawing window.
      '{8'h00, 1'b0, 1'b1, '{21'h00000, CELL_NARROW, 1'b0}},
      '{8'h7F, 1'b0, 1'b1, '{21'h0007F, CELL_NARROW, 1'b0}},
      '{8'h5F, 1'b1, 1'b1, '{21'h000A0, CELL_NARROW, 1'b0}},
      '{8'h7E, 1'b1, 1'b1, '{21'h000B7, CELL_NARROW, 1'b0}},
      '{8'h5E, 1'b1, 1'b1, '{21'h0005E, CELL_NARROW, 1'b0}},
      // Invalid lead bytes with no sequence open.
      '{8'h80, 1'b0, 1'b1, BAD_BYTE_RESULT},
      '{8'hFF, 1'b1, 1'b1, BAD_BYTE_RESULT},
      '{8'hF8, 1'b0, 1'b1, BAD_BYTE_RESULT},
      // Two, three and four byte sequences.
      '{8'hC3, 1'b0, 1'b0, '0},
      '{8'hA9, 1'b1, 1'b0, '0},
      '{8'hE4, 1'b0, 1'b0, '0},
      '{8'hB8, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b0, 1'b0, '0},
      '{8'h98, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      // Lead byte in the middle of a sequence is dropped, so the next byte decodes.
      '{8'hE2, 1'b0, 1'b0, '0},
      '{8'hC3, 1'b1, 1'b1, BAD_BYTE_RESULT},
      '{8'h42, 1'b1, 1'b1, '{21'h00042, CELL_NARROW, 1'b0}},
      // Overlong form of 0x5F is remapped like the plain byte.
      '{8'hC1, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b1, 1'b0, '0},
      // Largest four byte value.
      '{8'hF7, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b1, 1'b0, '0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // Decoder state mirrored by the testbench.
   logic [1:0]      open_left = 2'd0;
   logic [CP_W-1:0] gathered_bits = '0;

   rsp_type           pending_points [$];
   logic [BYTE_W-1:0] chunk_bytes [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                bytes_sent = 0;
   int                points_taken = 0;

   utf8_codepoint_width_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Remaps a completed ASCII code point when line drawing is on, then looks up its width.
   function automatic rsp_type settle_point(input logic [CP_W-1:0] cp, input logic dec_on);
      rsp_type res;
      res.code_point = cp;
      res.cell_width = CELL_NARROW;
      res.decode_error = 1'b0;
      if (dec_on && cp >= 21'h0005F && cp <= 21'h0007E) begin
         res.code_point = {5'd0, SPECIAL_GLYPHS[int'(cp) - 'h5F]};
      end
      if (res.code_point >= NARROW_BOUND) begin
         for (int i = 0; i < 16; i++) begin
            if (res.code_point >= WIDE_START[i] && res.code_point <= WIDE_STOP[i]) begin
               res.cell_width = CELL_WIDE;
            end
         end
      end
      return res;
   endfunction

   // Advances the decoder state by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_next_byte(input req_type item, output rsp_type res);
      logic [BYTE_W-1:0] b;
      b = item.data_byte;
      res = '0;
      if (open_left == 2'd0) begin
         if (!b[7]) begin
            res = settle_point({13'd0, b}, item.line_drawing);
            return 1'b1;
         end
         if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            gathered_bits = {16'd0, b[4:0]};
            open_left = 2'd1;
         end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            gathered_bits = {17'd0, b[3:0]};
            open_left = 2'd2;
         end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            gathered_bits = {18'd0, b[2:0]};
            open_left = 2'd3;
         end else begin
            res = BAD_BYTE_RESULT;
            return 1'b1;
         end
         return 1'b0;
      end
      // A non-continuation byte closes the open sequence and is dropped.
      if ((b & CONT_MASK) != CONT_PAT) begin
         open_left = 2'd0;
         res = BAD_BYTE_RESULT;
         return 1'b1;
      end
      gathered_bits = {gathered_bits[CP_W-7:0], b[5:0]};
      open_left = open_left - 2'd1;
      if (open_left == 2'd0) begin
         res = settle_point(gathered_bits, item.line_drawing);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Idle cycles before a transaction; some stretches run with no idling at all.
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic logic [BYTE_W-1:0] make_lead(input int len);
      case (len)
         2: return {3'b110, 5'($urandom)};
         3: return {4'b1110, 4'($urandom)};
         default: return $urandom_range(0, 1) ? 8'hF0 : {5'b11110, 3'($urandom)};
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] make_tail();
      return {2'b10, 6'($urandom)};
   endfunction

   // Shortest UTF-8 form of a code point.
   function automatic void encode_point(input logic [CP_W-1:0] cp);
      if (cp < 21'h80) begin
         chunk_bytes.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         chunk_bytes.push_back({3'b110, cp[10:6]});
         chunk_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         chunk_bytes.push_back({4'b1110, cp[15:12]});
         chunk_bytes.push_back({2'b10, cp[11:6]});
         chunk_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         chunk_bytes.push_back({5'b11110, cp[20:18]});
         chunk_bytes.push_back({2'b10, cp[17:12]});
         chunk_bytes.push_back({2'b10, cp[11:6]});
         chunk_bytes.push_back({2'b10, cp[5:0]});
      end
   endfunction

   // Fills chunk_bytes with one short piece of text: mostly well-formed, some broken.
   function automatic void build_chunk();
      int pick;
      int len;
      int idx;
      logic [BYTE_W-1:0] b;
      pick = $urandom_range(0, 99);
      chunk_bytes.delete();
      if (pick < 35) begin
         chunk_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 65) begin
         len = $urandom_range(2, 4);
         chunk_bytes.push_back(make_lead(len));
         for (int k = 1; k < len; k++) chunk_bytes.push_back(make_tail());
      end else if (pick < 80) begin
         // Edges of the wide ranges.
         idx = $urandom_range(0, 15);
         case ($urandom_range(0, 3))
            0: encode_point(WIDE_START[idx] - 21'd1);
            1: encode_point(WIDE_START[idx]);
            2: encode_point(WIDE_STOP[idx]);
            default: encode_point(WIDE_STOP[idx] + 21'd1);
         endcase
      end else if (pick < 90) begin
         // Sequence cut short by a byte that is not a continuation byte.
         len = $urandom_range(2, 4);
         chunk_bytes.push_back(make_lead(len));
         for (int k = $urandom_range(0, len - 2); k > 0; k--) chunk_bytes.push_back(make_tail());
         b = 8'($urandom);
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         chunk_bytes.push_back(b);
      end else begin
         chunk_bytes.push_back(8'($urandom));
      end
   endfunction

   // Offers one byte and records its expected result once the transaction is taken.
   task automatic send_byte(input req_type item, input bit preset, input rsp_type want);
      int gap;
      rsp_type got;
      gap = draw_gap((bytes_sent % 200) < 40);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (decode_next_byte(item, got)) begin
         pending_points.push_back(preset ? want : got);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   // Result side: pop with random stalls.
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = draw_gap((points_taken % 150) < 30);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         points_taken++;
         @(negedge clock);
      end
   end

   // Compare each popped result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result: code_point %h", rsp_data.code_point);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.code_point !== want.code_point) begin
               $error("code_point: expected %h, actual %h",
                      want.code_point, rsp_data.code_point);
               mismatch_count++;
            end
            if (rsp_data.cell_width !== want.cell_width) begin
               $error("cell_width: expected %0d, actual %0d",
                      want.cell_width, rsp_data.cell_width);
               mismatch_count++;
            end
            if (rsp_data.decode_error !== want.decode_error) begin
               $error("decode_error: expected %0d, actual %0d",
                      want.decode_error, rsp_data.decode_error);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Main sequence: reset, directed script, random text, drain.
   initial begin
      int random_sent;
      random_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_byte('{BYTE_SCRIPT[i].data_byte, BYTE_SCRIPT[i].line_drawing},
                   BYTE_SCRIPT[i].preset, BYTE_SCRIPT[i].want);
      end

      while (random_sent < RANDOM_BYTES) begin
         build_chunk();
         foreach (chunk_bytes[k]) begin
            send_byte('{chunk_bytes[k], 1'($urandom_range(0, 1))}, 1'b0, '0);
            random_sent++;
         end
      end
      req_push <= 1'b0;

      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
